FILE: src/uvs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// uvs_pkg
// shared constants, types and the arctangent table of the sphere tessellator
// ---------------------------------------------------------------------------
package uvs_pkg;

  localparam int unsigned MaxSlices = 256;
  localparam int unsigned MaxStacks = 256;
  localparam int unsigned CordicIter = 16;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw = $clog2(FifoDepth);

  localparam logic [31:0] GainQ30 = 32'd652032874;

  localparam logic [1:0] CfgRadius = 2'd0;
  localparam logic [1:0] CfgSlices = 2'd1;
  localparam logic [1:0] CfgStacks = 2'd2;

  typedef enum logic [1:0] {
    OP_VERTEX = 2'd0,
    OP_QUAD   = 2'd1,
    OP_BAD    = 2'd2
  } op_e;

  // classified request handed from the front end to the back end
  typedef struct packed {
    op_e         op;
    logic [8:0]  stack;
    logic [7:0]  slice;
    logic [8:0]  slices;
    logic [8:0]  stacks;
    logic [16:0] radius;
  } req_t;

  // one result item
  typedef struct packed {
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [16:0]        vertex_index;
    logic               last;
    logic               bad_request;
  } res_t;

  function automatic logic signed [35:0] atan_turn(input int unsigned k);
    logic signed [35:0] r;
    r = 36'sd0;
    unique case (k)
      0: r = 36'sh020000000;
      1: r = 36'sh012E4051E;
      2: r = 36'sh009FB385B;
      3: r = 36'sh0051111D4;
      4: r = 36'sh0028B0D43;
      5: r = 36'sh00145D7E1;
      6: r = 36'sh000A2F61E;
      7: r = 36'sh000517C55;
      8: r = 36'sh00028BE53;
      9: r = 36'sh000145F2F;
      10: r = 36'sh0000A2F98;
      11: r = 36'sh0000517CC;
      12: r = 36'sh000028BE6;
      13: r = 36'sh0000145F3;
      14: r = 36'sh00000A2FA;
      15: r = 36'sh00000517D;
      16: r = 36'sh0000028BE;
      17: r = 36'sh00000145F;
      18: r = 36'sh000000A30;
      19: r = 36'sh000000518;
      20: r = 36'sh00000028C;
      21: r = 36'sh000000146;
      22: r = 36'sh0000000A3;
      23: r = 36'sh000000051;
      default: r = 36'sd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/uvs_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// uvs_fifo
// short request queue between the front end and the back end
// ---------------------------------------------------------------------------
module uvs_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire uvs_pkg::req_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output uvs_pkg::req_t      pop_data_o,
  output logic               empty_o
);
  import uvs_pkg::*;

  req_t            mem_q [FifoDepth];
  logic [FifoAw:0] wr_q, rd_q;

  assign full_o     = (wr_q[FifoAw] != rd_q[FifoAw]) &&
                      (wr_q[FifoAw-1:0] == rd_q[FifoAw-1:0]);
  assign empty_o    = (wr_q == rd_q);
  assign pop_data_o = mem_q[rd_q[FifoAw-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_q[FifoAw-1:0]] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push_i && !full_o) wr_q <= wr_q + 1'b1;
      if (pop_i && !empty_o) rd_q <= rd_q + 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: src/uvs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// uvs_front
// accepts requests, applies effective sizes and checks the grid bounds
// ---------------------------------------------------------------------------
module uvs_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_idx_i,
  input  wire logic [15:0]   cfg_data_i,
  input  wire logic          in_valid_i,
  input  wire logic          in_kind_i,
  input  wire logic [8:0]    in_stack_i,
  input  wire logic [7:0]    in_slice_i,
  output logic               in_ready_o,
  output logic               push_o,
  output uvs_pkg::req_t      push_data_o,
  input  wire logic          full_i
);
  import uvs_pkg::*;

  logic [15:0] radius_q;
  logic [8:0]  slices_q, stacks_q;
  logic [8:0]  s_eff, t_eff;
  logic        bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd256;
      slices_q <= 9'd3;
      stacks_q <= 9'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRadius: radius_q <= cfg_data_i;
        CfgSlices: slices_q <= cfg_data_i[8:0];
        CfgStacks: stacks_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    s_eff = (slices_q > 9'(MaxSlices)) ? 9'(MaxSlices) : slices_q;
    if (s_eff < 9'd3) s_eff = 9'd3;
    t_eff = (stacks_q > 9'(MaxStacks)) ? 9'(MaxStacks) : stacks_q;
    if (t_eff < 9'd3) t_eff = 9'd3;
    bad = ({1'b0, in_slice_i} >= s_eff) ||
          (in_kind_i ? (in_stack_i >= t_eff) : (in_stack_i > t_eff));
    push_data_o.op     = bad ? OP_BAD : (in_kind_i ? OP_QUAD : OP_VERTEX);
    push_data_o.stack  = in_stack_i;
    push_data_o.slice  = in_slice_i;
    push_data_o.slices = s_eff;
    push_data_o.stacks = t_eff;
    push_data_o.radius = (radius_q == 16'd0) ? 17'd256 : {1'b0, radius_q};
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule
`default_nettype wire

FILE: src/uvs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// uvs_back
// vertex pipeline (angle, cordic rotation and vectoring) and quad sequencer
// ---------------------------------------------------------------------------
module uvs_back (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     empty_i,
  input  wire uvs_pkg::req_t req_i,
  output logic          pop_o,
  output logic          out_valid_o,
  output uvs_pkg::res_t out_data_o,
  input  wire logic     out_ready_i
);
  import uvs_pkg::*;

  localparam int unsigned N = CordicIter;
  // pipeline: 0 latches the dividend, 1..32 divide bits, then cordic
  localparam int unsigned DivBits = 32;
  // stage counts: divider, rotation, fold and products, vectoring, gain,
  // vectoring, final products
  localparam int unsigned L = 1 + DivBits + 1 + N + 2 + 1 + N + 1 + 1 + N + 1;

  typedef struct packed {
    logic [16:0]        idx;
    logic [16:0]        rad;
  } ctl_t;

  // ---------------- quad sequencer / issue ----------------
  logic [2:0]  qcnt_q;
  logic        adv;
  logic [16:0] lo, hi, jj, nn;
  logic [16:0] qidx;
  res_t        qres;
  logic        qv;

  // output register
  res_t        out_q;
  logic        outv_q;
  logic        take, issue_v;

  logic        pv_q  [L];
  logic        stall;
  logic        vpipe_busy;

  // the whole pipeline moves when the output can accept its head
  assign stall = pv_q[L-1] && outv_q && !out_ready_i;

  always_comb begin
    vpipe_busy = 1'b0;
    for (int k = 0; k < L; k++) vpipe_busy = vpipe_busy | pv_q[k];
  end

  always_comb begin
    lo = 17'({8'd0, req_i.stack} * {8'd0, req_i.slices});
    hi = 17'(lo + {8'd0, req_i.slices});
    jj = {9'd0, req_i.slice};
    nn = ({1'b0, req_i.slice} == req_i.slices - 9'd1) ? 17'd0 : 17'(jj + 17'd1);
    unique case (qcnt_q)
      3'd0: qidx = 17'(lo + jj);
      3'd1: qidx = 17'(hi + nn);
      3'd2: qidx = 17'(hi + jj);
      3'd3: qidx = 17'(lo + jj);
      3'd4: qidx = 17'(lo + nn);
      default: qidx = 17'(hi + nn);
    endcase
  end

  // quads and bad items go straight to output, but only when no vertex is ahead
  assign take    = !empty_i;
  always_comb begin
    qv      = 1'b0;
    issue_v = 1'b0;
    adv     = 1'b0;
    qres    = '0;
    if (take) begin
      unique case (req_i.op)
        OP_VERTEX: begin
          issue_v = !stall;
          adv     = issue_v;
        end
        OP_QUAD: begin
          qv = !vpipe_busy && (!outv_q || out_ready_i);
          qres.vertex_index = qidx;
          qres.last = (qcnt_q == 3'd5);
          adv = qv && (qcnt_q == 3'd5);
        end
        default: begin
          qv = !vpipe_busy && (!outv_q || out_ready_i);
          qres.last = 1'b1;
          qres.bad_request = 1'b1;
          adv = qv;
        end
      endcase
    end
  end
  assign pop_o = adv;

  // ---------------- vertex pipeline ----------------
  // angles by restoring division: th = (i<<31)/T, ph = (j<<32)/S
  logic [63:0] thn_q [DivBits+1];
  logic [31:0] thq_q [DivBits+1];
  logic [8:0]  thd_q [DivBits+1];
  logic [63:0] phn_q [DivBits+1];
  logic [31:0] phq_q [DivBits+1];
  logic [8:0]  phd_q [DivBits+1];
  ctl_t        dc_q  [DivBits+1];

  // division stage: remainder kept in top bits, one quotient bit per stage
  always_ff @(posedge clk_i) begin
    if (!stall) begin
      thn_q[0] <= {23'd0, req_i.stack, 32'd0} >> 1;
      thq_q[0] <= '0;
      thd_q[0] <= req_i.stacks;
      phn_q[0] <= {24'd0, req_i.slice, 32'd0};
      phq_q[0] <= '0;
      phd_q[0] <= req_i.slices;
      dc_q[0].idx <= 17'(lo + jj);
      dc_q[0].rad <= req_i.radius;
      for (int k = 0; k < DivBits; k++) begin
        logic [41:0] rt, rp;
        rt = 42'(thn_q[k] >> (31 - k));
        rp = 42'(phn_q[k] >> (31 - k));
        if (rt >= {33'd0, thd_q[k]}) begin
          thn_q[k+1] <= thn_q[k] - ({55'd0, thd_q[k]} << (31 - k));
          thq_q[k+1] <= thq_q[k] | (32'd1 << (31 - k));
        end else begin
          thn_q[k+1] <= thn_q[k];
          thq_q[k+1] <= thq_q[k];
        end
        if (rp >= {33'd0, phd_q[k]}) begin
          phn_q[k+1] <= phn_q[k] - ({55'd0, phd_q[k]} << (31 - k));
          phq_q[k+1] <= phq_q[k] | (32'd1 << (31 - k));
        end else begin
          phn_q[k+1] <= phn_q[k];
          phq_q[k+1] <= phq_q[k];
        end
        thd_q[k+1] <= thd_q[k];
        phd_q[k+1] <= phd_q[k];
        dc_q[k+1]  <= dc_q[k];
      end
    end
  end

  // rotation cordic for both angles in parallel
  logic signed [35:0] rx_q [2][N+1];
  logic signed [35:0] ry_q [2][N+1];
  logic signed [35:0] rz_q [2][N+1];
  logic [1:0]         rqd_q[2][N+1];
  ctl_t               rc_q [N+1];

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      for (int a = 0; a < 2; a++) begin
        logic [31:0] t;
        t = (a == 0) ? thq_q[DivBits] : phq_q[DivBits];
        rx_q[a][0]  <= 36'(signed'({1'b0, GainQ30}));
        ry_q[a][0]  <= '0;
        rz_q[a][0]  <= {6'd0, t[29:0]};
        rqd_q[a][0] <= t[31:30];
        for (int k = 0; k < N; k++) begin
          if (!rz_q[a][k][35]) begin
            rx_q[a][k+1] <= rx_q[a][k] - (ry_q[a][k] >>> k);
            ry_q[a][k+1] <= ry_q[a][k] + (rx_q[a][k] >>> k);
            rz_q[a][k+1] <= rz_q[a][k] - atan_turn(k);
          end else begin
            rx_q[a][k+1] <= rx_q[a][k] + (ry_q[a][k] >>> k);
            ry_q[a][k+1] <= ry_q[a][k] - (rx_q[a][k] >>> k);
            rz_q[a][k+1] <= rz_q[a][k] + atan_turn(k);
          end
          rqd_q[a][k+1] <= rqd_q[a][k];
        end
      end
      rc_q[0] <= dc_q[DivBits];
      for (int k = 0; k < N; k++) rc_q[k+1] <= rc_q[k];
    end
  end

  // quadrant fold, then normal products
  logic signed [35:0] c_q [2], s_q [2];
  ctl_t               qc_q;
  logic signed [35:0] nx_q, ny_q, nz_q;
  ctl_t               nc_q;

  function automatic logic signed [35:0] mq30(input logic signed [35:0] a,
                                             input logic signed [35:0] b);
    logic signed [71:0] p;
    p = a * b + 72'sd536870912;
    return 36'(p >>> 30);
  endfunction

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      for (int a = 0; a < 2; a++) begin
        unique case (rqd_q[a][N])
          2'd0: begin c_q[a] <= rx_q[a][N];  s_q[a] <= ry_q[a][N];  end
          2'd1: begin c_q[a] <= -ry_q[a][N]; s_q[a] <= rx_q[a][N];  end
          2'd2: begin c_q[a] <= -rx_q[a][N]; s_q[a] <= -ry_q[a][N]; end
          default: begin c_q[a] <= ry_q[a][N]; s_q[a] <= -rx_q[a][N]; end
        endcase
      end
      qc_q <= rc_q[N];
      nx_q <= mq30(s_q[0], c_q[1]);
      ny_q <= c_q[0];
      nz_q <= mq30(s_q[0], s_q[1]);
      nc_q <= qc_q;
    end
  end

  // first vectoring: magnitudes of (|ny|,|nz|) and (|nx|,|nz|)
  logic signed [35:0] vx_q [2][N+1];
  logic signed [35:0] vy_q [2][N+1];
  logic signed [35:0] va_q [2][N+1];
  logic signed [35:0] p3_q [3][N+1];
  ctl_t               vc_q [N+1];

  function automatic logic signed [35:0] abs36(input logic signed [35:0] v);
    return v[35] ? -v : v;
  endfunction

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      vx_q[0][0] <= abs36(ny_q); vy_q[0][0] <= abs36(nz_q); va_q[0][0] <= nx_q;
      vx_q[1][0] <= abs36(nx_q); vy_q[1][0] <= abs36(nz_q); va_q[1][0] <= ny_q;
      p3_q[0][0] <= nx_q; p3_q[1][0] <= ny_q; p3_q[2][0] <= nz_q;
      vc_q[0] <= nc_q;
      for (int k = 0; k < N; k++) begin
        for (int a = 0; a < 2; a++) begin
          if (!vy_q[a][k][35]) begin
            vx_q[a][k+1] <= vx_q[a][k] + (vy_q[a][k] >>> k);
            vy_q[a][k+1] <= vy_q[a][k] - (vx_q[a][k] >>> k);
          end else begin
            vx_q[a][k+1] <= vx_q[a][k] - (vy_q[a][k] >>> k);
            vy_q[a][k+1] <= vy_q[a][k] + (vx_q[a][k] >>> k);
          end
          va_q[a][k+1] <= va_q[a][k];
        end
        for (int c = 0; c < 3; c++) p3_q[c][k+1] <= p3_q[c][k];
        vc_q[k+1] <= vc_q[k];
      end
    end
  end

  // gain compensation
  logic signed [35:0] m_q [2], a_q [2], p4_q [3];
  ctl_t               mc_q;
  always_ff @(posedge clk_i) begin
    if (!stall) begin
      for (int a = 0; a < 2; a++) begin
        m_q[a] <= mq30(vx_q[a][N], 36'(signed'({1'b0, GainQ30})));
        a_q[a] <= va_q[a][N];
      end
      for (int c = 0; c < 3; c++) p4_q[c] <= p3_q[c][N];
      mc_q <= vc_q[N];
    end
  end

  // second vectoring: angle of (m, a)
  logic signed [35:0] wx_q [2][N+1];
  logic signed [35:0] wy_q [2][N+1];
  logic signed [35:0] wz_q [2][N+1];
  logic signed [35:0] p5_q [3][N+1];
  ctl_t               wc_q [N+1];
  always_ff @(posedge clk_i) begin
    if (!stall) begin
      for (int a = 0; a < 2; a++) begin
        wx_q[a][0] <= m_q[a]; wy_q[a][0] <= a_q[a]; wz_q[a][0] <= '0;
      end
      for (int c = 0; c < 3; c++) p5_q[c][0] <= p4_q[c];
      wc_q[0] <= mc_q;
      for (int k = 0; k < N; k++) begin
        for (int a = 0; a < 2; a++) begin
          if (!wy_q[a][k][35]) begin
            wx_q[a][k+1] <= wx_q[a][k] + (wy_q[a][k] >>> k);
            wy_q[a][k+1] <= wy_q[a][k] - (wx_q[a][k] >>> k);
            wz_q[a][k+1] <= wz_q[a][k] + atan_turn(k);
          end else begin
            wx_q[a][k+1] <= wx_q[a][k] - (wy_q[a][k] >>> k);
            wy_q[a][k+1] <= wy_q[a][k] + (wx_q[a][k] >>> k);
            wz_q[a][k+1] <= wz_q[a][k] - atan_turn(k);
          end
        end
        for (int c = 0; c < 3; c++) p5_q[c][k+1] <= p5_q[c][k];
        wc_q[k+1] <= wc_q[k];
      end
    end
  end

  // position products and final formatting
  logic signed [35:0] ps_q [3], nf_q [3], z_q [2];
  ctl_t               fc_q;
  res_t               vres;

  function automatic logic signed [35:0] clampv(input logic signed [35:0] v,
                                                input logic signed [35:0] lim);
    return (v > lim) ? lim : ((v < -lim) ? -lim : v);
  endfunction

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      for (int c = 0; c < 3; c++) begin
        ps_q[c] <= mq30(p5_q[c][N], {19'd0, wc_q[N].rad});
        nf_q[c] <= (p5_q[c][N] + 36'sd32768) >>> 16;
      end
      for (int a = 0; a < 2; a++) z_q[a] <= wz_q[a][N];
      fc_q <= wc_q[N];
    end
  end

  always_comb begin
    logic signed [35:0] t;
    vres = '0;
    vres.pos_x  = 17'(clampv(ps_q[0], 36'sd65535));
    vres.pos_y  = 17'(clampv(ps_q[1], 36'sd65535));
    vres.pos_z  = 17'(clampv(ps_q[2], 36'sd65535));
    vres.norm_x = 16'(clampv(nf_q[0], 36'sd16384));
    vres.norm_y = 16'(clampv(nf_q[1], 36'sd16384));
    vres.norm_z = 16'(clampv(nf_q[2], 36'sd16384));
    t = (2 * z_q[0] + 36'sh080000000 + 36'sd32768) >>> 16;
    vres.tex_u = (t < 0) ? 16'd0 : ((t > 36'sd65535) ? 16'hFFFF : t[15:0]);
    t = (2 * z_q[1] + 36'sh080000000 + 36'sd32768) >>> 16;
    vres.tex_v = (t < 0) ? 16'd0 : ((t > 36'sd65535) ? 16'hFFFF : t[15:0]);
    vres.vertex_index = fc_q.idx;
    vres.last = 1'b1;
  end

  // valid tracking across the whole pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < L; k++) pv_q[k] <= 1'b0;
    end else if (!stall) begin
      pv_q[0] <= issue_v;
      for (int k = 1; k < L; k++) pv_q[k] <= pv_q[k-1];
    end
  end

  // output register and quad counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outv_q <= 1'b0;
      qcnt_q <= '0;
    end else begin
      if (pv_q[L-1] && !stall) outv_q <= 1'b1;
      else if (qv) outv_q <= 1'b1;
      else if (out_ready_i) outv_q <= 1'b0;
      if (qv && req_i.op == OP_QUAD) qcnt_q <= (qcnt_q == 3'd5) ? 3'd0 : qcnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pv_q[L-1] && !stall) out_q <= vres;
    else if (qv) out_q <= qres;
  end

  assign out_valid_o = outv_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

FILE: src/uv_sphere_tessellator.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// uv_sphere_tessellator
// uv sphere vertex and quad index generator on stream ports
// ---------------------------------------------------------------------------
// vertex path: a request passes 88 pipeline stages (33 angle divider,
//   three 16-step cordic chains with fold, product and gain stages) and
//   then the output register; quad and off-grid requests are written to
//   the output register straight from the queue
// throughput: one vertex request per cycle while the output does not stall;
//   a quad holds the back end for six results, after earlier vertices drain
// reset: radius 1.0, slice and stack counts 3, queue and pipeline emptied
module uv_sphere_tessellator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // stack_idx[8:0], slice_idx[16:9]
  input  wire logic        s_axis_tuser,  // kind
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v, vertex_index
  output logic [151:0]     m_axis_tdata,
  output logic             m_axis_tlast,
  output logic             m_axis_tuser   // bad_request
);
  import uvs_pkg::*;

  req_t push_data, pop_data;
  res_t res;
  logic push, full, pop, empty;

  uvs_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_stack_i (s_axis_tdata[8:0]),
    .in_slice_i (s_axis_tdata[16:9]),
    .in_ready_o (s_axis_tready),
    .push_o     (push),
    .push_data_o(push_data),
    .full_i     (full)
  );

  uvs_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .pop_data_o(pop_data), .empty_o(empty)
  );

  uvs_back u_back (
    .clk_i, .rst_ni,
    .empty_i(empty), .req_i(pop_data), .pop_o(pop),
    .out_valid_o(m_axis_tvalid), .out_data_o(res), .out_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {4'd0, res.vertex_index, res.tex_v, res.tex_u,
                         res.norm_z, res.norm_y, res.norm_x,
                         res.pos_z, res.pos_y, res.pos_x};
  assign m_axis_tlast = res.last;
  assign m_axis_tuser = res.bad_request;

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uv sphere tessellator testbench
// drives vertex and quad requests under several sphere settings and checks
// every result against a bit-exact fixed-point cordic model of the sphere
// ---------------------------------------------------------------------------
module testbench;
  import uvs_pkg::*;

  // arctangent of 2^-k in fractions of a full turn, signed, 32 fraction bits
  localparam longint ATAN_TURN [16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
  };
  localparam longint CORDIC_GAIN = 64'd652032874;
  localparam longint HALF_Q30 = 64'sd1 << 29;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 250;

  // -------------------------------------------------------------------------
  // expected sphere results, kept in request order
  // -------------------------------------------------------------------------
  class sphere_scoreboard;
    res_t        sphere_q[$];
    int unsigned radius_reg, slices_reg, stacks_reg;
    int          errors;

    function new();
      radius_reg = 256;
      slices_reg = 3;
      stacks_reg = 3;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] value);
      case (idx)
        CfgRadius: radius_reg = {16'd0, value};
        CfgSlices: slices_reg = {23'd0, value[8:0]};
        CfgStacks: stacks_reg = {23'd0, value[8:0]};
        default: ;
      endcase
    endfunction

    function void add_result(res_t r);
      sphere_q.insert(sphere_q.size(), r);
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint mul_q30(longint a, longint b);
      return (a * b + HALF_Q30) >>> 30;
    endfunction

    // rotation mode cordic, quadrant taken from the top two angle bits
    function void sin_cos(longint angle, output longint c, output longint s);
      longint x, y, z, dx, dy;
      x = CORDIC_GAIN;
      y = 0;
      z = angle & 64'h3FFFFFFF;
      for (int k = 0; k < 16; k++) begin
        dx = y >>> k;
        dy = x >>> k;
        if (z >= 0) begin
          x -= dx; y += dy; z -= ATAN_TURN[k];
        end else begin
          x += dx; y -= dy; z += ATAN_TURN[k];
        end
      end
      case ((angle >> 30) & 3)
        0: begin c = x;  s = y;  end
        1: begin c = -y; s = x;  end
        2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    // vectoring mode: angle in turn units, gain-corrected magnitude
    function longint vector_angle(longint x, longint y, output longint mag);
      longint z, dx, dy;
      z = 0;
      for (int k = 0; k < 16; k++) begin
        dx = y >>> k;
        dy = x >>> k;
        if (y >= 0) begin
          x += dx; y -= dy; z += ATAN_TURN[k];
        end else begin
          x -= dx; y += dy; z -= ATAN_TURN[k];
        end
      end
      mag = (x * CORDIC_GAIN + HALF_Q30) >>> 30;
      return z;
    endfunction

    // asin(a)/pi + 0.5 with p, q the other two normal components
    function logic [15:0] tex_coord(longint a, longint p, longint q);
      longint m, z;
      z = vector_angle(p < 0 ? -p : p, q < 0 ? -q : q, m);
      z = vector_angle(m, a, m);
      return 16'(clamp((2 * z + (64'sd1 << 31) + (64'sd1 << 15)) >>> 16, 0, 65535));
    endfunction

    function void note_request(op_e kind, logic [8:0] stack, logic [7:0] slice);
      longint s_eff, t_eff, rad, th, ph, ct, st, cp, sp, nx, ny, nz, nxt;
      res_t r;
      s_eff = clamp(slices_reg, 3, MaxSlices);
      t_eff = clamp(stacks_reg, 3, MaxStacks);
      rad = radius_reg == 0 ? 256 : radius_reg;
      r = '0;
      r.last = 1'b1;
      // off grid: a vertex may sit on the far pole row, a quad may not
      if (slice >= s_eff || (kind == OP_VERTEX ? stack > t_eff : stack >= t_eff)) begin
        r.bad_request = 1'b1;
        add_result(r);
      end else if (kind == OP_VERTEX) begin
        th = (longint'(stack) << 31) / t_eff;
        ph = (longint'(slice) << 32) / s_eff;
        sin_cos(th, ct, st);
        sin_cos(ph, cp, sp);
        nx = mul_q30(st, cp);
        ny = ct;
        nz = mul_q30(st, sp);
        r.pos_x = 17'(clamp(mul_q30(nx, rad), -65535, 65535));
        r.pos_y = 17'(clamp(mul_q30(ny, rad), -65535, 65535));
        r.pos_z = 17'(clamp(mul_q30(nz, rad), -65535, 65535));
        r.norm_x = 16'(clamp((nx + 32768) >>> 16, -16384, 16384));
        r.norm_y = 16'(clamp((ny + 32768) >>> 16, -16384, 16384));
        r.norm_z = 16'(clamp((nz + 32768) >>> 16, -16384, 16384));
        r.tex_u = tex_coord(nx, ny, nz);
        r.tex_v = tex_coord(ny, nx, nz);
        r.vertex_index = 17'(stack * s_eff + slice);
        add_result(r);
      end else begin
        longint lo, hi, nxt_idx [6];
        // slice after the last one wraps around to zero
        nxt = (slice == s_eff - 1) ? 0 : slice + 1;
        lo = stack * s_eff;
        hi = (stack + 1) * s_eff;
        nxt_idx = '{lo + slice, hi + nxt, hi + slice, lo + slice, lo + nxt, hi + nxt};
        for (int k = 0; k < 6; k++) begin
          r = '0;
          r.vertex_index = 17'(nxt_idx[k]);
          r.last = (k == 5);
          add_result(r);
        end
      end
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_result(res_t got);
      res_t e;
      if (sphere_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      e = sphere_q.pop_front();
      if (got.pos_x !== e.pos_x) report($sformatf("pos_x %0d exp %0d", got.pos_x, e.pos_x));
      if (got.pos_y !== e.pos_y) report($sformatf("pos_y %0d exp %0d", got.pos_y, e.pos_y));
      if (got.pos_z !== e.pos_z) report($sformatf("pos_z %0d exp %0d", got.pos_z, e.pos_z));
      if (got.norm_x !== e.norm_x)
        report($sformatf("norm_x %0d exp %0d", got.norm_x, e.norm_x));
      if (got.norm_y !== e.norm_y)
        report($sformatf("norm_y %0d exp %0d", got.norm_y, e.norm_y));
      if (got.norm_z !== e.norm_z)
        report($sformatf("norm_z %0d exp %0d", got.norm_z, e.norm_z));
      if (got.tex_u !== e.tex_u) report($sformatf("tex_u %0d exp %0d", got.tex_u, e.tex_u));
      if (got.tex_v !== e.tex_v) report($sformatf("tex_v %0d exp %0d", got.tex_v, e.tex_v));
      if (got.vertex_index !== e.vertex_index)
        report($sformatf("vertex_index %0d exp %0d", got.vertex_index, e.vertex_index));
      if (got.last !== e.last) report($sformatf("last %b exp %b", got.last, e.last));
      if (got.bad_request !== e.bad_request)
        report($sformatf("bad_request %b exp %b", got.bad_request, e.bad_request));
    endtask
  endclass

  // -------------------------------------------------------------------------
  // block hookup
  // -------------------------------------------------------------------------
  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_idx = CfgRadius;
  logic [15:0]  cfg_data = '0;
  logic         s_valid = 1'b0;
  logic         s_ready;
  logic [23:0]  s_data = '0;
  logic         s_user = 1'b0;
  logic         m_valid;
  logic         m_ready = 1'b0;
  logic [151:0] m_data;
  logic         m_last;
  logic         m_user;

  uv_sphere_tessellator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),   // stack_idx[8:0], slice_idx[16:9]
    .s_axis_tuser  (s_user),   // kind
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v, vertex_index
    .m_axis_tdata  (m_data),
    .m_axis_tlast  (m_last),
    .m_axis_tuser  (m_user)    // bad_request
  );

  sphere_scoreboard sphere_sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;
  int quiet_cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // receiver: random back pressure, or a long hold to fill the block up
  always @(posedge clk_i) begin
    m_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor both handshakes on the sampled edge values
  always @(posedge clk_i) begin
    res_t got;
    if (s_valid && s_ready)
      sphere_sb.note_request(op_e'({1'b0, s_user}), s_data[8:0], s_data[16:9]);
    if (m_valid && m_ready) begin
      got.pos_x = m_data[16:0];
      got.pos_y = m_data[33:17];
      got.pos_z = m_data[50:34];
      got.norm_x = m_data[66:51];
      got.norm_y = m_data[82:67];
      got.norm_z = m_data[98:83];
      got.tex_u = m_data[114:99];
      got.tex_v = m_data[130:115];
      got.vertex_index = m_data[147:131];
      got.last = m_last;
      got.bad_request = m_user;
      sphere_sb.check_result(got);
    end
  end

  // watchdog: too long with no request or result moving
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request, held until taken, then maybe a random gap
  task send_request(op_e kind, logic [8:0] stack, logic [7:0] slice);
    s_valid <= 1'b1;
    s_user <= kind[0];
    s_data <= {7'd0, slice, stack};
    do @(posedge clk_i); while (!s_ready);
    if ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // registers only change once the block has fully drained
  task set_sphere(logic [15:0] radius, logic [8:0] slices, logic [8:0] stacks);
    s_valid <= 1'b0;
    while (sphere_sb.sphere_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    for (int r = 0; r < 3; r++) begin
      cfg_we <= 1'b1;
      cfg_idx <= r[1:0];
      cfg_data <= (r == 0) ? radius : (r == 1) ? {7'd0, slices} : {7'd0, stacks};
      sphere_sb.write_reg(r[1:0], (r == 0) ? radius : (r == 1) ? {7'd0, slices}
                                                              : {7'd0, stacks});
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  // mostly on-grid requests, some anywhere in the field ranges
  task random_requests(int count);
    int s_eff, t_eff;
    op_e kind;
    s_eff = sphere_sb.slices_reg < 3 ? 3 : (sphere_sb.slices_reg > 256 ? 256
                                                                       : sphere_sb.slices_reg);
    t_eff = sphere_sb.stacks_reg < 3 ? 3 : (sphere_sb.stacks_reg > 256 ? 256
                                                                       : sphere_sb.stacks_reg);
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(1) ? OP_QUAD : OP_VERTEX;
      if ($urandom_range(99) < 85)
        send_request(kind, 9'($urandom_range(kind == OP_QUAD ? t_eff - 1 : t_eff)),
                     8'($urandom_range(s_eff - 1)));
      else
        send_request(kind, 9'($urandom_range(511)), 8'($urandom_range(255)));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // smallest sphere: zero radius and counts below the minimum
    set_sphere(16'd0, 9'd0, 9'd0);
    send_request(OP_VERTEX, 9'd0, 8'd0);    // north pole
    send_request(OP_VERTEX, 9'd3, 8'd0);    // south pole row is allowed
    send_request(OP_VERTEX, 9'd3, 8'd2);
    send_request(OP_VERTEX, 9'd1, 8'd1);
    send_request(OP_VERTEX, 9'd2, 8'd2);
    send_request(OP_VERTEX, 9'd4, 8'd0);    // past the pole
    send_request(OP_VERTEX, 9'd0, 8'd3);    // slice off the grid
    send_request(OP_VERTEX, 9'd511, 8'd255);
    send_request(OP_QUAD, 9'd0, 8'd0);
    send_request(OP_QUAD, 9'd2, 8'd2);      // slice wraps to zero
    send_request(OP_QUAD, 9'd3, 8'd0);      // quad on the last row is off grid
    send_request(OP_QUAD, 9'd0, 8'd3);
    send_request(OP_QUAD, 9'd511, 8'd255);

    // largest sphere, sender idles lightly, receiver heavily
    set_sphere(16'hFFFF, 9'd256, 9'd256);
    send_idle_pct = 23;
    recv_idle_pct = 65;
    send_request(OP_VERTEX, 9'd256, 8'd255);
    send_request(OP_VERTEX, 9'd128, 8'd64);
    send_request(OP_QUAD, 9'd255, 8'd255);  // top index corner of the grid
    send_request(OP_VERTEX, 9'd256, 8'd128);
    fork
      begin
        recv_hold = 1'b1;
        repeat (400) @(posedge clk_i);
        recv_hold = 1'b0;
      end
    join_none
    random_requests(35);

    // the oversized slice count saturates; now the receiver is the lighter one
    set_sphere(16'h1234, 9'h1FF, 9'd37);
    send_idle_pct = 65;
    recv_idle_pct = 23;
    random_requests(30);

    // mid sized sphere at full rate
    set_sphere(16'($urandom_range(65535)), 9'($urandom_range(3, 40)),
               9'($urandom_range(3, 40)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_requests(35);

    s_valid <= 1'b0;
    while (sphere_sb.sphere_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sphere_sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
